/* hw/rtl/terminal_escape_sequence_parser_macros.svh */
// Assertion macros for the terminal escape-sequence parser.
// No dependencies; included by the modules that carry assertions.
`ifndef TERMINAL_ESCAPE_SEQUENCE_PARSER_MACROS_SVH
`define TERMINAL_ESCAPE_SEQUENCE_PARSER_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge out of reset
`define TESP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");
// expr must never be true out of reset
`define TESP_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define TESP_ASSERT(label, clk, rst_n, prop)
`define TESP_NEVER(label, clk, rst_n, expr)
`endif

`endif

/* hw/rtl/tesp_pkg.sv */
// Shared types, constants and decode functions for the escape-sequence parser.
// No dependencies; used by every module of the block.
package tesp_pkg;

    localparam int CP_W        = 21;
    localparam int QUEUE_DEPTH = 4;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // register map (index = paddr / 4)
    localparam logic REG_CHAR_MODE = 1'b0;

    // char_mode codes; code 3 masks like seven-bit
    localparam logic [1:0] MODE_FULL  = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_SEVEN = 2'd2;

    // notable code points
    localparam logic [CP_W-1:0] CH_CAN     = 21'h18;
    localparam logic [CP_W-1:0] CH_SUB     = 21'h1a;
    localparam logic [CP_W-1:0] CH_ESC     = 21'h1b;
    localparam logic [CP_W-1:0] CH_SPACE   = 21'h20;
    localparam logic [CP_W-1:0] CH_DIGIT0  = 21'h30;
    localparam logic [CP_W-1:0] CH_COLON   = 21'h3a;
    localparam logic [CP_W-1:0] CH_PRIV_LO = 21'h3c;
    localparam logic [CP_W-1:0] CH_UPPER   = 21'h40;
    localparam logic [CP_W-1:0] CH_P       = 21'h50;
    localparam logic [CP_W-1:0] CH_X       = 21'h58;
    localparam logic [CP_W-1:0] CH_LBRK    = 21'h5b;
    localparam logic [CP_W-1:0] CH_RBRK    = 21'h5d;
    localparam logic [CP_W-1:0] CH_CARET   = 21'h5e;
    localparam logic [CP_W-1:0] CH_UNDER   = 21'h5f;
    localparam logic [CP_W-1:0] CH_DEL     = 21'h7f;
    localparam logic [CP_W-1:0] CH_C1_LO   = 21'h80;
    localparam logic [CP_W-1:0] CH_C1_8F   = 21'h8f;
    localparam logic [CP_W-1:0] CH_DCS     = 21'h90;
    localparam logic [CP_W-1:0] CH_C1_91   = 21'h91;
    localparam logic [CP_W-1:0] CH_C1_97   = 21'h97;
    localparam logic [CP_W-1:0] CH_SOS     = 21'h98;
    localparam logic [CP_W-1:0] CH_C1_99   = 21'h99;
    localparam logic [CP_W-1:0] CH_C1_9A   = 21'h9a;
    localparam logic [CP_W-1:0] CH_CSI     = 21'h9b;
    localparam logic [CP_W-1:0] CH_ST      = 21'h9c;
    localparam logic [CP_W-1:0] CH_OSC     = 21'h9d;
    localparam logic [CP_W-1:0] CH_PM      = 21'h9e;
    localparam logic [CP_W-1:0] CH_APC     = 21'h9f;

    typedef enum logic [3:0] {
        ST_GROUND     = 4'd0,
        ST_ESC        = 4'd1,
        ST_ESC_INT    = 4'd2,
        ST_CSI_ENTRY  = 4'd3,
        ST_CSI_PARAM  = 4'd4,
        ST_CSI_INT    = 4'd5,
        ST_CSI_IGNORE = 4'd6,
        ST_DCS_ENTRY  = 4'd7,
        ST_DCS_PARAM  = 4'd8,
        ST_DCS_INT    = 4'd9,
        ST_DCS_PASS   = 4'd10,
        ST_DCS_IGNORE = 4'd11,
        ST_OSC_STRING = 4'd12,
        ST_ST_IGNORE  = 4'd13
    } state_t;

    typedef enum logic [3:0] {
        ACT_NONE        = 4'd0,
        ACT_IGNORE      = 4'd1,
        ACT_PRINT       = 4'd2,
        ACT_EXECUTE     = 4'd3,
        ACT_CLEAR       = 4'd4,
        ACT_COLLECT     = 4'd5,
        ACT_PARAM       = 4'd6,
        ACT_ESC_DISP    = 4'd7,
        ACT_CSI_DISP    = 4'd8,
        ACT_DCS_START   = 4'd9,
        ACT_DCS_COLLECT = 4'd10,
        ACT_DCS_END     = 4'd11,
        ACT_OSC_START   = 4'd12,
        ACT_OSC_COLLECT = 4'd13,
        ACT_OSC_END     = 4'd14
    } act_t;

    // character classes; G_* act from any state
    typedef enum logic [4:0] {
        CL_G_EXEC,   // CAN, SUB, plain C1 controls
        CL_G_ESC,    // ESC
        CL_G_SOS,    // SOS, PM, APC
        CL_G_DCS,    // 8-bit DCS
        CL_G_OSC,    // 8-bit OSC
        CL_G_CSI,    // 8-bit CSI
        CL_C0,       // other C0 controls
        CL_INTER,    // 0x20-0x2f
        CL_PARAM,    // digits and ';'
        CL_COLON,    // ':'
        CL_PRIV,     // 0x3c-0x3f
        CL_DCS_P,    // 'P'
        CL_CSI_B,    // '['
        CL_OSC_B,    // ']'
        CL_SOS_B,    // 'X', '^', '_'
        CL_FINAL,    // rest of 0x40-0x7e
        CL_DEL,      // 0x7f
        CL_HIGH      // 0xa0 and above
    } cls_t;

    typedef struct packed {
        cls_t            cls;
        logic [CP_W-1:0] ch;
    } entry_t;

    typedef struct packed {
        logic   moves;
        state_t to;
        act_t   act;
    } step_t;

    function automatic logic [CP_W-1:0] mask_char(logic [CP_W-1:0] c, logic [1:0] mode);
        logic [CP_W-1:0] r;
        case (mode)
            MODE_FULL: r = c;
            MODE_BYTE: r = {{(CP_W-8){1'b0}}, c[7:0]};
            default:   r = {{(CP_W-7){1'b0}}, c[6:0]};
        endcase
        return r;
    endfunction

    function automatic cls_t classify(logic [CP_W-1:0] c);
        cls_t r;
        if (c == CH_CAN || c == CH_SUB || (c >= CH_C1_LO && c <= CH_C1_8F) ||
            (c >= CH_C1_91 && c <= CH_C1_97) || c == CH_C1_99 || c == CH_C1_9A ||
            c == CH_ST)
            r = CL_G_EXEC;
        else if (c == CH_ESC)
            r = CL_G_ESC;
        else if (c == CH_SOS || c == CH_PM || c == CH_APC)
            r = CL_G_SOS;
        else if (c == CH_DCS)
            r = CL_G_DCS;
        else if (c == CH_OSC)
            r = CL_G_OSC;
        else if (c == CH_CSI)
            r = CL_G_CSI;
        else if (c < CH_SPACE)
            r = CL_C0;
        else if (c < CH_DIGIT0)
            r = CL_INTER;
        else if (c == CH_COLON)
            r = CL_COLON;
        else if (c < CH_PRIV_LO)
            r = CL_PARAM;
        else if (c < CH_UPPER)
            r = CL_PRIV;
        else if (c == CH_P)
            r = CL_DCS_P;
        else if (c == CH_LBRK)
            r = CL_CSI_B;
        else if (c == CH_RBRK)
            r = CL_OSC_B;
        else if (c == CH_X || c == CH_CARET || c == CH_UNDER)
            r = CL_SOS_B;
        else if (c < CH_DEL)
            r = CL_FINAL;
        else if (c == CH_DEL)
            r = CL_DEL;
        else
            r = CL_HIGH;
        return r;
    endfunction

    function automatic step_t go(state_t to, act_t act);
        step_t r;
        r.moves = 1'b1;
        r.to    = to;
        r.act   = act;
        return r;
    endfunction

    function automatic step_t stay(act_t act);
        step_t r;
        r.moves = 1'b0;
        r.to    = ST_GROUND;
        r.act   = act;
        return r;
    endfunction

    function automatic act_t entry_of(state_t s);
        act_t r;
        case (s)
            ST_ESC, ST_CSI_ENTRY, ST_DCS_ENTRY: r = ACT_CLEAR;
            ST_DCS_PASS:                        r = ACT_DCS_START;
            ST_OSC_STRING:                      r = ACT_OSC_START;
            default:                            r = ACT_NONE;
        endcase
        return r;
    endfunction

    function automatic act_t exit_of(state_t s);
        act_t r;
        case (s)
            ST_DCS_PASS:   r = ACT_DCS_END;
            ST_OSC_STRING: r = ACT_OSC_END;
            default:       r = ACT_NONE;
        endcase
        return r;
    endfunction

    // one transition: global controls first, then the state's own table
    function automatic step_t decide(cls_t cl, state_t s);
        step_t r;
        r = stay(ACT_IGNORE);
        case (cl)
            CL_G_EXEC: r = go(ST_GROUND, ACT_EXECUTE);
            CL_G_ESC:  r = go(ST_ESC, ACT_NONE);
            CL_G_SOS:  r = go(ST_ST_IGNORE, ACT_NONE);
            CL_G_DCS:  r = go(ST_DCS_ENTRY, ACT_NONE);
            CL_G_OSC:  r = go(ST_OSC_STRING, ACT_NONE);
            CL_G_CSI:  r = go(ST_CSI_ENTRY, ACT_NONE);
            default:
            begin
                case (s)
                    ST_ESC:
                    begin
                        case (cl)
                            CL_DCS_P: r = go(ST_DCS_ENTRY, ACT_NONE);
                            CL_CSI_B: r = go(ST_CSI_ENTRY, ACT_NONE);
                            CL_OSC_B: r = go(ST_OSC_STRING, ACT_NONE);
                            CL_SOS_B: r = go(ST_ST_IGNORE, ACT_NONE);
                            CL_DEL:   r = stay(ACT_IGNORE);
                            CL_C0:    r = stay(ACT_EXECUTE);
                            CL_PARAM, CL_COLON, CL_PRIV, CL_FINAL:
                                      r = go(ST_GROUND, ACT_ESC_DISP);
                            default:  r = go(ST_ESC_INT, ACT_COLLECT);
                        endcase
                    end
                    ST_ESC_INT:
                    begin
                        case (cl)
                            CL_C0:             r = stay(ACT_EXECUTE);
                            CL_DEL:            r = stay(ACT_IGNORE);
                            CL_INTER, CL_HIGH: r = stay(ACT_COLLECT);
                            default:           r = go(ST_GROUND, ACT_ESC_DISP);
                        endcase
                    end
                    ST_CSI_ENTRY:
                    begin
                        case (cl)
                            CL_COLON: r = go(ST_CSI_IGNORE, ACT_NONE);
                            CL_DEL:   r = stay(ACT_IGNORE);
                            CL_C0:    r = stay(ACT_EXECUTE);
                            CL_INTER: r = go(ST_CSI_INT, ACT_COLLECT);
                            CL_PARAM: r = go(ST_CSI_PARAM, ACT_PARAM);
                            CL_PRIV:  r = go(ST_CSI_PARAM, ACT_COLLECT);
                            CL_HIGH:  r = go(ST_CSI_IGNORE, ACT_NONE);
                            default:  r = go(ST_GROUND, ACT_CSI_DISP);
                        endcase
                    end
                    ST_CSI_PARAM:
                    begin
                        case (cl)
                            CL_DEL:   r = stay(ACT_IGNORE);
                            CL_C0:    r = stay(ACT_EXECUTE);
                            CL_INTER: r = go(ST_CSI_INT, ACT_COLLECT);
                            CL_PARAM: r = stay(ACT_PARAM);
                            CL_COLON, CL_PRIV, CL_HIGH:
                                      r = go(ST_CSI_IGNORE, ACT_NONE);
                            default:  r = go(ST_GROUND, ACT_CSI_DISP);
                        endcase
                    end
                    ST_CSI_INT:
                    begin
                        case (cl)
                            CL_C0:    r = stay(ACT_EXECUTE);
                            CL_INTER: r = stay(ACT_COLLECT);
                            CL_DEL:   r = stay(ACT_IGNORE);
                            CL_PARAM, CL_COLON, CL_PRIV, CL_HIGH:
                                      r = go(ST_CSI_IGNORE, ACT_NONE);
                            default:  r = go(ST_GROUND, ACT_CSI_DISP);
                        endcase
                    end
                    ST_CSI_IGNORE:
                    begin
                        case (cl)
                            CL_C0:   r = stay(ACT_EXECUTE);
                            CL_FINAL, CL_DCS_P, CL_CSI_B, CL_OSC_B, CL_SOS_B:
                                     r = go(ST_GROUND, ACT_NONE);
                            default: r = stay(ACT_IGNORE);
                        endcase
                    end
                    ST_DCS_ENTRY:
                    begin
                        case (cl)
                            CL_COLON:      r = go(ST_DCS_IGNORE, ACT_NONE);
                            CL_DEL, CL_C0: r = stay(ACT_IGNORE);
                            CL_INTER:      r = go(ST_DCS_INT, ACT_COLLECT);
                            CL_PARAM:      r = go(ST_DCS_PARAM, ACT_PARAM);
                            CL_PRIV:       r = go(ST_DCS_PARAM, ACT_COLLECT);
                            default:       r = go(ST_DCS_PASS, ACT_NONE);
                        endcase
                    end
                    ST_DCS_PARAM:
                    begin
                        case (cl)
                            CL_DEL, CL_C0:     r = stay(ACT_IGNORE);
                            CL_INTER:          r = go(ST_DCS_INT, ACT_COLLECT);
                            CL_PARAM:          r = stay(ACT_PARAM);
                            CL_COLON, CL_PRIV: r = go(ST_DCS_IGNORE, ACT_NONE);
                            default:           r = go(ST_DCS_PASS, ACT_NONE);
                        endcase
                    end
                    ST_DCS_INT:
                    begin
                        case (cl)
                            CL_DEL, CL_C0: r = stay(ACT_IGNORE);
                            CL_INTER:      r = stay(ACT_COLLECT);
                            CL_PARAM, CL_COLON, CL_PRIV:
                                           r = go(ST_DCS_IGNORE, ACT_NONE);
                            default:       r = go(ST_DCS_PASS, ACT_NONE);
                        endcase
                    end
                    ST_DCS_PASS:
                    begin
                        case (cl)
                            CL_DEL:  r = stay(ACT_IGNORE);
                            default: r = stay(ACT_DCS_COLLECT);
                        endcase
                    end
                    ST_OSC_STRING:
                    begin
                        case (cl)
                            CL_C0:   r = stay(ACT_IGNORE);
                            default: r = stay(ACT_OSC_COLLECT);
                        endcase
                    end
                    ST_DCS_IGNORE, ST_ST_IGNORE:
                    begin
                        r = stay(ACT_IGNORE);
                    end
                    default:
                    begin
                        // ground
                        case (cl)
                            CL_C0:   r = stay(ACT_EXECUTE);
                            default: r = stay(ACT_PRINT);
                        endcase
                    end
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/tesp_front.sv */
// Front end: mode register on the APB port, masking and classification
// of incoming code points. Depends on tesp_pkg.
module tesp_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tesp_pkg::APB_AW-1:0]    paddr,
    input  logic [tesp_pkg::APB_DW-1:0]    pwdata,
    output logic [tesp_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    input  logic                           push,
    input  logic [tesp_pkg::CP_W-1:0]      code_point,
    input  logic                           q_full,
    output logic                           wr_en,
    output tesp_pkg::entry_t               wr_data
);

    logic [1:0] char_mode_reg;
    logic [1:0] char_mode_next;
    logic       reg_idx;
    logic       cfg_wr;
    logic [tesp_pkg::CP_W-1:0] ch;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel & penable & pwrite;

    always_comb
    begin
        char_mode_next = char_mode_reg;
        if (cfg_wr && reg_idx == tesp_pkg::REG_CHAR_MODE)
        begin
            char_mode_next = pwdata[1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == tesp_pkg::REG_CHAR_MODE)
        begin
            prdata = {{(tesp_pkg::APB_DW-2){1'b0}}, char_mode_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_mode_reg <= tesp_pkg::MODE_FULL;
        end
        else
        begin
            char_mode_reg <= char_mode_next;
        end
    end

    assign ch          = tesp_pkg::mask_char(code_point, char_mode_reg);
    assign wr_en       = push & ~q_full;
    assign wr_data.ch  = ch;
    assign wr_data.cls = tesp_pkg::classify(ch);

endmodule

/* hw/rtl/tesp_queue.sv */
// Short queue of classified characters between front and back end.
// Depends on tesp_pkg and the assertion macro header.
`include "terminal_escape_sequence_parser_macros.svh"

module tesp_queue
#(
    parameter int DEPTH = tesp_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  tesp_pkg::entry_t wr_data,
    output logic             full,
    output logic             rd_valid,
    input  logic             rd_en,
    output tesp_pkg::entry_t rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tesp_pkg::entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    `TESP_NEVER(a_q_overfill, clk, rst_n, count_reg > CNT_W'(DEPTH))
    `TESP_NEVER(a_q_pop_empty, clk, rst_n, rd_en && (count_reg == '0))
    `TESP_ASSERT(a_q_count_up, clk, rst_n, (wr_en && !rd_en) |=> (count_reg == $past(count_reg) + 1'b1))

endmodule

/* hw/rtl/tesp_back.sv */
// Back end: parser state register, transition decode and result register.
// Depends on tesp_pkg and the assertion macro header.
`include "terminal_escape_sequence_parser_macros.svh"

module tesp_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  tesp_pkg::entry_t          q_data,
    output logic                      q_rd,
    output logic                      empty,
    input  logic                      pop,
    output logic [3:0]                exit_act,
    output logic [3:0]                main_act,
    output logic [3:0]                entry_act,
    output logic [tesp_pkg::CP_W-1:0] char_out,
    output logic [3:0]                next_state
);

    tesp_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    tesp_pkg::act_t   exit_act_reg, exit_act_next;
    tesp_pkg::act_t   main_act_reg, main_act_next;
    tesp_pkg::act_t   entry_act_reg, entry_act_next;
    logic [tesp_pkg::CP_W-1:0] char_out_reg, char_out_next;
    tesp_pkg::state_t next_state_reg, next_state_next;

    tesp_pkg::step_t  step;
    logic             take;

    // result slot is free, or is being drained this cycle
    assign take = q_valid & (~out_valid_reg | pop);
    assign q_rd = take;
    assign step = tesp_pkg::decide(q_data.cls, state_reg);

    always_comb
    begin
        exit_act_next   = tesp_pkg::ACT_NONE;
        entry_act_next  = tesp_pkg::ACT_NONE;
        next_state_next = state_reg;
        main_act_next   = step.act;
        char_out_next   = q_data.ch;
        if (step.moves)
        begin
            exit_act_next   = tesp_pkg::exit_of(state_reg);
            entry_act_next  = tesp_pkg::entry_of(step.to);
            next_state_next = step.to;
        end
    end

    always_comb
    begin
        state_next     = take ? next_state_next : state_reg;
        out_valid_next = take | (out_valid_reg & ~pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tesp_pkg::ST_GROUND;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            exit_act_reg   <= exit_act_next;
            main_act_reg   <= main_act_next;
            entry_act_reg  <= entry_act_next;
            char_out_reg   <= char_out_next;
            next_state_reg <= next_state_next;
        end
    end

    assign empty      = ~out_valid_reg;
    assign exit_act   = exit_act_reg;
    assign main_act   = main_act_reg;
    assign entry_act  = entry_act_reg;
    assign char_out   = char_out_reg;
    assign next_state = next_state_reg;

    `TESP_ASSERT(a_result_tracks_state, clk, rst_n, take |=> (next_state_reg == state_reg))
    `TESP_ASSERT(a_stay_holds_state, clk, rst_n, (take && !step.moves) |=> (state_reg == $past(state_reg)))
    `TESP_ASSERT(a_osc_entry_dest, clk, rst_n, (out_valid_reg && entry_act_reg == tesp_pkg::ACT_OSC_START) |-> (next_state_reg == tesp_pkg::ST_OSC_STRING))

endmodule

/* hw/rtl/terminal_escape_sequence_parser.sv */
// Top level of the terminal escape-sequence parser.
// Depends on tesp_pkg, tesp_front, tesp_queue and tesp_back.
//
//   channel   handshake             payload
//   -------   --------------------  ------------------------------------------
//   input     push / full           code_point
//   result    empty / pop           exit_act, main_act, entry_act, char_out,
//                                   next_state
//   config    APB psel/penable      char_mode at byte address 0
//
// One code point in and one result out per clock when nothing stalls.
// A word passes through the combinational classify stage into the queue, then
// through the transition decode into the result register.
// The parser state is a single register updated as each word leaves the
// queue, so consecutive words chain through it at full rate.
// Reset (rst_n low, asynchronous) empties the queue and the result slot,
// puts the parser in ground and char_mode to full code point.
// A stalled result side fills the queue; full rises only when QUEUE_DEPTH
// words wait behind the held result.
module terminal_escape_sequence_parser
#(
    parameter int QUEUE_DEPTH = tesp_pkg::QUEUE_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tesp_pkg::APB_AW-1:0]    paddr,
    input  logic [tesp_pkg::APB_DW-1:0]    pwdata,
    output logic [tesp_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    // input words
    input  logic                           push,
    output logic                           full,
    input  logic [tesp_pkg::CP_W-1:0]      code_point,
    // result words
    output logic                           empty,
    input  logic                           pop,
    output logic [3:0]                     exit_act,
    output logic [3:0]                     main_act,
    output logic [3:0]                     entry_act,
    output logic [tesp_pkg::CP_W-1:0]      char_out,
    output logic [3:0]                     next_state
);

    logic             q_wr;
    logic             q_full;
    logic             q_valid;
    logic             q_rd;
    tesp_pkg::entry_t q_wdata;
    tesp_pkg::entry_t q_rdata;

    assign full = q_full;

    // masking by char_mode and character classification
    tesp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .push       (push),
        .code_point (code_point),
        .q_full     (q_full),
        .wr_en      (q_wr),
        .wr_data    (q_wdata)
    );

    // decouples the classify stage from result back-pressure
    tesp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr),
        .wr_data  (q_wdata),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_en    (q_rd),
        .rd_data  (q_rdata)
    );

    // state transition and result register
    tesp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_rdata),
        .q_rd       (q_rd),
        .empty      (empty),
        .pop        (pop),
        .exit_act   (exit_act),
        .main_act   (main_act),
        .entry_act  (entry_act),
        .char_out   (char_out),
        .next_state (next_state)
    );

endmodule

/* tb/tb_terminal_escape_sequence_parser.sv */
// Self-checking testbench for terminal_escape_sequence_parser: queue-style input and
// result ports, APB char_mode register, predictor run on every accepted word.
// Depends on tesp_pkg and the parser RTL only.
module tb_terminal_escape_sequence_parser;

    timeunit 1ns;
    timeprecision 1ps;

    import tesp_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 4;          // margin after the last result is popped
    localparam int HOLD_CYCLES   = 40;         // long result stall to fill the queue
    localparam int TIMEOUT_NS    = 5_000_000;

    // register map: char_mode at index 0, index 1 is unmapped
    localparam logic [APB_AW-1:0] ADDR_CHAR_MODE = APB_AW'(int'(REG_CHAR_MODE) * 4);
    localparam logic [APB_AW-1:0] ADDR_SPARE     = APB_AW'(4);

    // mode code that the hardware treats like seven-bit
    localparam logic [1:0] MODE_SEVEN_ALT = 2'd3;

    localparam logic [CP_W-1:0] BYTE_MASK  = 21'hff;
    localparam logic [CP_W-1:0] SEVEN_MASK = 21'h7f;
    localparam logic [CP_W-1:0] CH_BEL     = 21'h07;
    localparam logic [CP_W-1:0] CH_SEMI    = 21'h3b;
    localparam logic [CP_W-1:0] CH_BSLASH  = 21'h5c;

    // Opening run in full mode: code point extremes, then one pass through
    // each sequence type so that every action code shows up at least once.
    localparam logic [CP_W-1:0] OPENING_CHARS [25] = '{
        21'h000000,     // C0 in ground: execute
        21'h10ffff,     // top legal code point: print
        21'h1b,         // ESC: clear on entry
        21'h5b,         // '[' into CSI entry
        21'h3f,         // private marker: collect
        21'h31,         // digit: param, state unchanged
        21'h3a,         // colon kills the CSI
        21'h41,         // final leaves CSI ignore, no action
        21'h9b,         // 8-bit CSI
        21'h20,         // intermediate
        21'h6d,         // csi dispatch
        21'h1b,
        21'h28,         // ESC intermediate
        21'h42,         // esc dispatch
        21'h90,         // 8-bit DCS
        21'h31,
        21'h71,         // into passthrough: dcs_start on entry
        21'h1fffff,     // all ones, beyond legal range: still collected
        21'h9c,         // ST: dcs_end on exit, execute
        21'h9d,         // 8-bit OSC: osc_start
        21'h41,         // osc collect
        21'h07,         // BEL inside OSC is ignored
        21'h18,         // CAN: osc_end on exit
        21'h98,         // SOS string
        21'h1a          // SUB back to ground
    };

    // one transition of the parser
    typedef struct packed {
        logic   moves;
        state_t to;
        act_t   act;
    } hop_t;

    // one result word as the block reports it
    typedef struct packed {
        act_t            exit_a;
        act_t            main_a;
        act_t            entry_a;
        logic [CP_W-1:0] ch;
        state_t          state_after;
    } parser_word_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [APB_AW-1:0]   paddr      = '0;
    logic [APB_DW-1:0]   pwdata     = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                push       = 1'b0;
    logic                full;
    logic [CP_W-1:0]     code_point = '0;
    logic                empty;
    logic                pop        = 1'b0;
    logic [3:0]          exit_act;
    logic [3:0]          main_act;
    logic [3:0]          entry_act;
    logic [CP_W-1:0]     char_out;
    logic [3:0]          next_state;

    // predictor copy of the block's state and register
    state_t              model_state = ST_GROUND;
    logic [1:0]          model_mode  = MODE_FULL;

    logic [CP_W-1:0]     queued_chars[$];       // words waiting to be offered
    parser_word_t        predicted_actions[$];  // results still owed by the block

    int                  error_count  = 0;
    bit                  steady_run   = 1'b0;   // no idling on either side
    bit                  hold_request = 1'b0;
    bit                  hold_off     = 1'b0;
    bit                  char_taken   = 1'b0;   // input handshake done at last edge
    bit                  word_taken   = 1'b0;   // result handshake done at last edge
    int unsigned         send_gap     = 0;
    int unsigned         pop_gap      = 0;

    terminal_escape_sequence_parser u_dut
    (
        .clk,
        .rst_n,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready,
        .push,
        .full,
        .code_point,
        .empty,
        .pop,
        .exit_act,
        .main_act,
        .entry_act,
        .char_out,
        .next_state
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic hop_t hop_to(state_t to, act_t act);
        hop_t h;
        h.moves = 1'b1;
        h.to    = to;
        h.act   = act;
        return h;
    endfunction

    function automatic hop_t hop_stay(act_t act);
        hop_t h;
        h.moves = 1'b0;
        h.to    = ST_GROUND;
        h.act   = act;
        return h;
    endfunction

    // Global controls win over any state; otherwise the state's own table
    // decides. c is already masked.
    function automatic hop_t parse_step(logic [CP_W-1:0] c, state_t s);
        hop_t h;
        if (c == CH_CAN || c == CH_SUB || (c >= CH_C1_LO && c <= CH_C1_8F) ||
            (c >= CH_C1_91 && c <= CH_C1_97) || c == CH_C1_99 || c == CH_C1_9A ||
            c == CH_ST)
            h = hop_to(ST_GROUND, ACT_EXECUTE);
        else if (c == CH_ESC)
            h = hop_to(ST_ESC, ACT_NONE);
        else if (c == CH_SOS || c == CH_PM || c == CH_APC)
            h = hop_to(ST_ST_IGNORE, ACT_NONE);
        else if (c == CH_DCS)
            h = hop_to(ST_DCS_ENTRY, ACT_NONE);
        else if (c == CH_OSC)
            h = hop_to(ST_OSC_STRING, ACT_NONE);
        else if (c == CH_CSI)
            h = hop_to(ST_CSI_ENTRY, ACT_NONE);
        else
        begin
            case (s)
                ST_ESC:
                begin
                    if (c == CH_P)                          h = hop_to(ST_DCS_ENTRY, ACT_NONE);
                    else if (c == CH_LBRK)                  h = hop_to(ST_CSI_ENTRY, ACT_NONE);
                    else if (c == CH_RBRK)                  h = hop_to(ST_OSC_STRING, ACT_NONE);
                    else if (c == CH_X || c == CH_CARET || c == CH_UNDER)
                                                            h = hop_to(ST_ST_IGNORE, ACT_NONE);
                    else if (c == CH_DEL)                   h = hop_stay(ACT_IGNORE);
                    else if (c < CH_SPACE)                  h = hop_stay(ACT_EXECUTE);
                    else if (c >= CH_DIGIT0 && c < CH_C1_LO) h = hop_to(ST_GROUND, ACT_ESC_DISP);
                    else                                    h = hop_to(ST_ESC_INT, ACT_COLLECT);
                end
                ST_ESC_INT:
                begin
                    if (c < CH_SPACE)                       h = hop_stay(ACT_EXECUTE);
                    else if (c >= CH_DIGIT0 && c < CH_DEL)  h = hop_to(ST_GROUND, ACT_ESC_DISP);
                    else if (c == CH_DEL)                   h = hop_stay(ACT_IGNORE);
                    else                                    h = hop_stay(ACT_COLLECT);
                end
                ST_CSI_ENTRY:
                begin
                    if (c == CH_COLON)                      h = hop_to(ST_CSI_IGNORE, ACT_NONE);
                    else if (c == CH_DEL)                   h = hop_stay(ACT_IGNORE);
                    else if (c < CH_SPACE)                  h = hop_stay(ACT_EXECUTE);
                    else if (c < CH_DIGIT0)                 h = hop_to(ST_CSI_INT, ACT_COLLECT);
                    else if (c < CH_PRIV_LO)                h = hop_to(ST_CSI_PARAM, ACT_PARAM);
                    else if (c < CH_UPPER)                  h = hop_to(ST_CSI_PARAM, ACT_COLLECT);
                    else if (c < CH_C1_LO)                  h = hop_to(ST_GROUND, ACT_CSI_DISP);
                    else                                    h = hop_to(ST_CSI_IGNORE, ACT_NONE);
                end
                ST_CSI_PARAM:
                begin
                    if (c == CH_COLON)                      h = hop_to(ST_CSI_IGNORE, ACT_NONE);
                    else if (c == CH_DEL)                   h = hop_stay(ACT_IGNORE);
                    else if (c < CH_SPACE)                  h = hop_stay(ACT_EXECUTE);
                    else if (c < CH_DIGIT0)                 h = hop_to(ST_CSI_INT, ACT_COLLECT);
                    else if (c < CH_PRIV_LO)                h = hop_stay(ACT_PARAM);
                    else if (c >= CH_UPPER && c < CH_C1_LO) h = hop_to(ST_GROUND, ACT_CSI_DISP);
                    else                                    h = hop_to(ST_CSI_IGNORE, ACT_NONE);
                end
                ST_CSI_INT:
                begin
                    if (c < CH_SPACE)                       h = hop_stay(ACT_EXECUTE);
                    else if (c < CH_DIGIT0)                 h = hop_stay(ACT_COLLECT);
                    else if (c >= CH_UPPER && c < CH_DEL)   h = hop_to(ST_GROUND, ACT_CSI_DISP);
                    else if (c == CH_DEL)                   h = hop_stay(ACT_IGNORE);
                    else                                    h = hop_to(ST_CSI_IGNORE, ACT_NONE);
                end
                ST_CSI_IGNORE:
                begin
                    if (c < CH_SPACE)                       h = hop_stay(ACT_EXECUTE);
                    else if (c >= CH_UPPER && c < CH_DEL)   h = hop_to(ST_GROUND, ACT_NONE);
                    else                                    h = hop_stay(ACT_IGNORE);
                end
                ST_DCS_ENTRY:
                begin
                    if (c == CH_COLON)                      h = hop_to(ST_DCS_IGNORE, ACT_NONE);
                    else if (c == CH_DEL || c < CH_SPACE)   h = hop_stay(ACT_IGNORE);
                    else if (c < CH_DIGIT0)                 h = hop_to(ST_DCS_INT, ACT_COLLECT);
                    else if (c < CH_PRIV_LO)                h = hop_to(ST_DCS_PARAM, ACT_PARAM);
                    else if (c < CH_UPPER)                  h = hop_to(ST_DCS_PARAM, ACT_COLLECT);
                    else                                    h = hop_to(ST_DCS_PASS, ACT_NONE);
                end
                ST_DCS_PARAM:
                begin
                    if (c < CH_SPACE || c == CH_DEL)        h = hop_stay(ACT_IGNORE);
                    else if (c < CH_DIGIT0)                 h = hop_to(ST_DCS_INT, ACT_COLLECT);
                    else if (c < CH_COLON || c == CH_SEMI)  h = hop_stay(ACT_PARAM);
                    else if (c < CH_UPPER)                  h = hop_to(ST_DCS_IGNORE, ACT_NONE);
                    else                                    h = hop_to(ST_DCS_PASS, ACT_NONE);
                end
                ST_DCS_INT:
                begin
                    if (c < CH_SPACE || c == CH_DEL)        h = hop_stay(ACT_IGNORE);
                    else if (c < CH_DIGIT0)                 h = hop_stay(ACT_COLLECT);
                    else if (c < CH_UPPER)                  h = hop_to(ST_DCS_IGNORE, ACT_NONE);
                    else                                    h = hop_to(ST_DCS_PASS, ACT_NONE);
                end
                ST_DCS_PASS:
                begin
                    if (c == CH_DEL)                        h = hop_stay(ACT_IGNORE);
                    else                                    h = hop_stay(ACT_DCS_COLLECT);
                end
                ST_OSC_STRING:
                begin
                    if (c < CH_SPACE)                       h = hop_stay(ACT_IGNORE);
                    else                                    h = hop_stay(ACT_OSC_COLLECT);
                end
                ST_DCS_IGNORE, ST_ST_IGNORE:
                    h = hop_stay(ACT_IGNORE);
                default:
                begin
                    // ground, and any code that should never be stored
                    if (c < CH_SPACE)                       h = hop_stay(ACT_EXECUTE);
                    else                                    h = hop_stay(ACT_PRINT);
                end
            endcase
        end
        return h;
    endfunction

    // Mask the accepted word, run one transition and queue the result.
    // Exit and entry actions appear only when the transition moves, even
    // when it lands back on the same state.
    function automatic void predict_word(logic [CP_W-1:0] raw);
        logic [CP_W-1:0] c;
        hop_t            h;
        parser_word_t    w;
        c = raw;
        if (model_mode == MODE_BYTE)
            c = c & BYTE_MASK;
        else if (model_mode != MODE_FULL)
            c = c & SEVEN_MASK;
        h = parse_step(c, model_state);
        w.exit_a      = ACT_NONE;
        w.main_a      = h.act;
        w.entry_a     = ACT_NONE;
        w.ch          = c;
        w.state_after = model_state;
        if (h.moves)
        begin
            case (model_state)
                ST_DCS_PASS:   w.exit_a = ACT_DCS_END;
                ST_OSC_STRING: w.exit_a = ACT_OSC_END;
                default:       w.exit_a = ACT_NONE;
            endcase
            case (h.to)
                ST_ESC, ST_CSI_ENTRY, ST_DCS_ENTRY: w.entry_a = ACT_CLEAR;
                ST_DCS_PASS:                        w.entry_a = ACT_DCS_START;
                ST_OSC_STRING:                      w.entry_a = ACT_OSC_START;
                default:                            w.entry_a = ACT_NONE;
            endcase
            w.state_after = h.to;
        end
        model_state = w.state_after;
        predicted_actions.push_back(w);
    endfunction

    function automatic void check_field(string name, logic [CP_W-1:0] want,
                                        logic [CP_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int unsigned pick_wait();
        return steady_run ? 0 : $urandom_range(6, 0);
    endfunction

    // random code point in [lo, hi]
    function automatic logic [CP_W-1:0] rnd_char(logic [CP_W-1:0] hi, logic [CP_W-1:0] lo);
        return CP_W'($urandom_range(32'(hi), 32'(lo)));
    endfunction

    // In the masked modes half the words carry junk in the bits that the
    // block must drop.
    function automatic void add_char(logic [CP_W-1:0] c);
        logic [CP_W-1:0] junk;
        logic [CP_W-1:0] w;
        junk = CP_W'($urandom);
        w    = c;
        if ($urandom_range(1, 0) == 1)
        begin
            if (model_mode == MODE_BYTE)
                w = w | (junk & ~BYTE_MASK);
            else if (model_mode != MODE_FULL)
                w = w | (junk & ~SEVEN_MASK);
        end
        queued_chars.push_back(w);
    endfunction

    // sequence opener: the 8-bit C1 form or ESC plus its 7-bit letter
    function automatic void add_intro(logic [CP_W-1:0] c1, logic [CP_W-1:0] letter);
        if ($urandom_range(1, 0) == 1)
            add_char(c1);
        else
        begin
            add_char(CH_ESC);
            add_char(letter);
        end
    endfunction

    function automatic void add_string_end();
        if ($urandom_range(1, 0) == 1)
            add_char(CH_ST);
        else
        begin
            add_char(CH_ESC);
            add_char(CH_BSLASH);
        end
    endfunction

    // Mostly well-formed sequences with random content; five kinds in twelve are
    // raw noise, stray C1 controls and CSIs cut short by arbitrary bytes.
    function automatic void queue_traffic(int count);
        int goal;
        int kind;
        goal = queued_chars.size() + count;
        while (queued_chars.size() < goal)
        begin
            kind = $urandom_range(11, 0);
            case (kind)
                0:
                begin
                    // text run, sometimes beyond Latin-1
                    repeat ($urandom_range(6, 1))
                        add_char(($urandom_range(3, 0) != 0) ? rnd_char(21'h7e, 21'h20)
                                                             : rnd_char(21'h10ffff, 21'ha0));
                end
                1:
                    add_char(($urandom_range(3, 0) != 0) ? rnd_char(21'h1f, 21'h00)
                                                         : CH_DEL);
                2:
                begin
                    add_char(CH_ESC);
                    repeat ($urandom_range(2, 0))
                        add_char(rnd_char(21'h2f, 21'h20));
                    add_char(rnd_char(21'h7e, 21'h30));
                end
                3:
                begin
                    add_intro(CH_CSI, CH_LBRK);
                    if ($urandom_range(2, 0) == 0)
                        add_char(rnd_char(21'h3f, 21'h3c));
                    repeat ($urandom_range(5, 0))
                    begin
                        case ($urandom_range(9, 0))
                            0:       add_char(CH_SEMI);
                            1:       add_char(CH_COLON);
                            2:       add_char(rnd_char(21'h1f, 21'h00));
                            3:       add_char(CH_DEL);
                            default: add_char(rnd_char(21'h39, 21'h30));
                        endcase
                    end
                    if ($urandom_range(3, 0) == 0)
                        add_char(rnd_char(21'h2f, 21'h20));
                    add_char(rnd_char(21'h7e, 21'h40));
                end
                4:
                begin
                    add_intro(CH_DCS, CH_P);
                    repeat ($urandom_range(3, 0))
                        add_char(($urandom_range(3, 0) != 0) ? rnd_char(21'h39, 21'h30)
                                                             : CH_SEMI);
                    if ($urandom_range(3, 0) == 0)
                        add_char(rnd_char(21'h2f, 21'h20));
                    add_char(rnd_char(21'h7e, 21'h40));
                    repeat ($urandom_range(6, 1))
                        add_char(($urandom_range(3, 0) != 0) ? rnd_char(21'h7f, 21'h20)
                                                             : rnd_char(21'h1fffff, 21'ha0));
                    add_string_end();
                end
                5:
                begin
                    add_intro(CH_OSC, CH_RBRK);
                    repeat ($urandom_range(6, 1))
                        add_char(rnd_char(21'h7e, 21'h20));
                    if ($urandom_range(1, 0) == 1)
                        add_char(CH_BEL);   // ignored inside the string
                    add_string_end();
                end
                6:
                begin
                    case ($urandom_range(2, 0))
                        0:       add_intro(CH_SOS, CH_X);
                        1:       add_intro(CH_PM, CH_CARET);
                        default: add_intro(CH_APC, CH_UNDER);
                    endcase
                    repeat ($urandom_range(4, 0))
                        add_char(rnd_char(21'hff, 21'h00));
                    add_string_end();
                end
                7:
                    add_char(rnd_char(21'h9f, 21'h80));
                8:
                begin
                    // CSI cut short by arbitrary bytes
                    add_intro(CH_CSI, CH_LBRK);
                    repeat ($urandom_range(4, 1))
                        add_char(rnd_char(21'hff, 21'h00));
                end
                9, 10:
                    add_char(CP_W'($urandom));
                default:
                    add_char(rnd_char(21'hff, 21'h00));
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // APB access, driven on the falling edge
    // ------------------------------------------------------------------

    task automatic reg_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // only index 0 is a register; other indexes drop the write
        if (addr[APB_AW-1:2] == REG_CHAR_MODE)
            model_mode = data[1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_char_mode();
        logic [APB_DW-1:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_CHAR_MODE;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== APB_DW'(model_mode))
        begin
            $error("char_mode readback: expected %0d, got %0d", model_mode, got);
            error_count++;
        end
    endtask

    // Config writes go only into an idle block: every queued word offered,
    // every predicted result popped, then a settle wait for the pipeline.
    task automatic wait_drained();
        while (queued_chars.size() != 0 || push || predicted_actions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Input side: driver on negedge, acceptance seen on posedge
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin : feed_chars
        logic offer;
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            offer = push;
            if (char_taken)
            begin
                char_taken = 1'b0;
                offer      = 1'b0;
                send_gap   = pick_wait();
            end
            if (!offer)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (queued_chars.size() > 0)
                begin
                    code_point <= queued_chars.pop_front();
                    offer = 1'b1;
                end
            end
            // one assignment per step so a back-to-back word keeps push high
            push <= offer;
        end
    end

    always @(posedge clk)
    begin : take_chars
        if (rst_n && push && !full)
        begin
            predict_word(code_point);
            char_taken = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result side: pop driver on negedge, compare on posedge
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin : drain_words
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (word_taken)
            begin
                word_taken = 1'b0;
                pop_gap    = pick_wait();
            end
            if (hold_off)
                pop <= 1'b0;
            else if (pop_gap > 0)
            begin
                pop_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_words
        parser_word_t want;
        if (rst_n && pop && !empty)
        begin
            word_taken = 1'b1;
            if (predicted_actions.size() == 0)
            begin
                $error("result word with nothing predicted: char_out 0x%0h state %0d",
                       char_out, next_state);
                error_count++;
            end
            else
            begin
                want = predicted_actions.pop_front();
                check_field("exit_act",   CP_W'(want.exit_a),      CP_W'(exit_act));
                check_field("main_act",   CP_W'(want.main_a),      CP_W'(main_act));
                check_field("entry_act",  CP_W'(want.entry_a),     CP_W'(entry_act));
                check_field("char_out",   want.ch,                 char_out);
                check_field("next_state", CP_W'(want.state_after), CP_W'(next_state));
            end
        end
    end

    // Long result stall while the sender keeps going: the queue fills and
    // full has to hold the input off without losing a word.
    initial
    begin : stall_results
        wait (hold_request);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin : run_test
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // reset value of char_mode, then the directed run in full mode
        check_char_mode();
        foreach (OPENING_CHARS[i])
            add_char(OPENING_CHARS[i]);
        wait_drained();

        // byte mode: high bits must vanish, 8-bit CSI hidden in a wide word
        reg_write(ADDR_CHAR_MODE, {30'($urandom), MODE_BYTE});
        check_char_mode();
        add_char(21'h1fff9b);
        add_char(21'h012341);
        queue_traffic(80);
        wait_drained();

        // unmapped index must not disturb char_mode; then seven-bit, no idling
        reg_write(ADDR_SPARE, $urandom);
        check_char_mode();
        reg_write(ADDR_CHAR_MODE, {30'($urandom), MODE_SEVEN});
        check_char_mode();
        steady_run = 1'b1;
        queue_traffic(80);
        wait_drained();

        // spare mode code masks like seven-bit: 0x..db lands on '['
        reg_write(ADDR_CHAR_MODE, {30'($urandom), MODE_SEVEN_ALT});
        check_char_mode();
        steady_run = 1'b0;
        add_char(21'h1fffdb);
        queue_traffic(60);
        wait_drained();

        // full mode at full rate with the long result stall
        reg_write(ADDR_CHAR_MODE, {30'($urandom), MODE_FULL});
        check_char_mode();
        steady_run   = 1'b1;
        hold_request = 1'b1;
        queue_traffic(120);
        wait_drained();

        // back to byte mode with random idling on both sides
        reg_write(ADDR_CHAR_MODE, {30'($urandom), MODE_BYTE});
        check_char_mode();
        steady_run = 1'b0;
        queue_traffic(100);
        wait_drained();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
